[rtl/fpsa_pkg.sv]
// Shared constants and types for the fit-policy segment allocator.
// No dependencies.
package fpsa_pkg;

  localparam int MaxSegmentsDefault = 64;
  localparam int SizeBitsDefault    = 20;
  localparam int OwnerBitsDefault   = 16;

  // policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // status codes
  localparam logic [1:0] ST_GRANT = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // config register indexes
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_TOTAL  = 1'b1;

  // command broadcast to the cell chain
  typedef struct packed {
    logic init;    // load cell 0 as one free segment, clear the rest
    logic rotate;  // shift every cell one place toward the head, tail takes head
    logic write;   // head entry is replaced by the write fields on its way to the tail
    logic ins;     // start carrying a free remainder in behind the written head
  } chain_cmd_t;

endpackage

[rtl/fpsa_cell.sv]
// One cell of the segment ring: holds a size, an owner and a used flag.
// Depends on fpsa_pkg.
module fpsa_cell
  import fpsa_pkg::*;
#(
  parameter int SizeBits  = SizeBitsDefault,
  parameter int OwnerBits = OwnerBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 clear,
  input  logic [SizeBits-1:0]  size_in,
  input  logic [OwnerBits-1:0] owner_in,
  input  logic                 used_in,
  output logic [SizeBits-1:0]  size,
  output logic [OwnerBits-1:0] owner,
  output logic                 used
);

  // payload moves when loaded; used flag is control state
  // (a load during reset is the table init and wins over reset)
  always_ff @(posedge clk) begin
    if (load) begin
      size  <= size_in;
      owner <= owner_in;
    end
    if (clear) begin
      used <= 1'b0;
    end else if (load) begin
      used <= used_in;
    end else if (rst) begin
      used <= 1'b0;
    end
  end

endmodule

[rtl/fpsa_chain.sv]
// Ring of fpsa_cell: each rotation passes every entry one cell along.
// Depends on fpsa_pkg, fpsa_cell.
module fpsa_chain
  import fpsa_pkg::*;
#(
  parameter int MaxSegments = MaxSegmentsDefault,
  parameter int SizeBits    = SizeBitsDefault,
  parameter int OwnerBits   = OwnerBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  chain_cmd_t           cmd,
  input  logic [SizeBits-1:0]  wr_size,
  input  logic [OwnerBits-1:0] wr_owner,
  input  logic [SizeBits-1:0]  ins_size,
  output logic [SizeBits-1:0]  head_size,
  output logic [OwnerBits-1:0] head_owner,
  output logic                 head_used
);

  logic [SizeBits-1:0]  sz  [MaxSegments];
  logic [OwnerBits-1:0] ow  [MaxSegments];
  logic                 us  [MaxSegments];

  logic [SizeBits-1:0]  carry_size;
  logic [OwnerBits-1:0] carry_owner;
  logic                 carry_valid;

  // Ring order: cell 0 is the head, entry k sits in cell k at rest.
  // A rotation moves cell k+1 into cell k; the head leaves to the tail.
  // An insert leaves the free remainder in a carry stage one step behind
  // the written head; while carrying, the tail takes the carry and the
  // carry takes the head, until an unused head entry is dropped.
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      carry_valid <= 1'b0;
    end else if (cmd.rotate) begin
      if (cmd.ins) begin
        carry_valid <= 1'b1;
        carry_size  <= ins_size;
        carry_owner <= '0;
      end else if (carry_valid) begin
        carry_valid <= us[0];
        carry_size  <= sz[0];
        carry_owner <= ow[0];
      end
    end
  end

  for (genvar k = 0; k < MaxSegments; k++) begin : g_cell
    logic [SizeBits-1:0]  s_in;
    logic [OwnerBits-1:0] o_in;
    logic                 u_in;
    logic                 ld;
    if (k == MaxSegments - 1) begin : g_tail
      always_comb begin
        ld = cmd.rotate;
        if (cmd.write) begin
          s_in = wr_size;
          o_in = wr_owner;
          u_in = us[0];
        end else if (carry_valid) begin
          s_in = carry_size;
          o_in = carry_owner;
          u_in = 1'b1;
        end else begin
          s_in = sz[0];
          o_in = ow[0];
          u_in = us[0];
        end
      end
    end else begin : g_mid
      always_comb begin
        ld   = cmd.rotate;
        s_in = sz[k+1];
        o_in = ow[k+1];
        u_in = us[k+1];
      end
    end
    logic do_ld;
    logic [SizeBits-1:0]  s_fin;
    logic [OwnerBits-1:0] o_fin;
    logic                 u_fin;
    always_comb begin
      do_ld = ld;
      s_fin = s_in;
      o_fin = o_in;
      u_fin = u_in;
      if (cmd.init && k == 0) begin
        do_ld = 1'b1;
        s_fin = wr_size;
        o_fin = '0;
        u_fin = 1'b1;
      end
    end
    fpsa_cell #(.SizeBits(SizeBits), .OwnerBits(OwnerBits)) u_cell (
      .clk(clk), .rst(rst), .load(do_ld), .clear(cmd.init && k != 0),
      .size_in(s_fin), .owner_in(o_fin), .used_in(u_fin),
      .size(sz[k]), .owner(ow[k]), .used(us[k])
    );
  end

  assign head_size  = sz[0];
  assign head_owner = ow[0];
  assign head_used  = us[0];

endmodule

[rtl/fit_policy_segment_allocator_top.sv]
// Top level of the fit-policy segment allocator: control sequencer and ports.
// Depends on fpsa_pkg, fpsa_chain (fpsa_cell).
//
// Usage:
//   Requests (request_size, owner_id) enter on the valid/ready input channel;
//   each gives one result (status, segment_index, was_split) on the output
//   channel. Config writes (cfg_index, cfg_data) set the policy (index 0) or
//   reload the table as one free segment of total_memory (index 1).
//   The segment table lives in a ring of MaxSegments cells; only the head
//   cell is examined. A request takes two full rotations of the ring: the
//   first scans every entry and picks a segment, the second writes the pick
//   and, on a split, slides the free remainder in right behind it.
//   A grant shows on out_valid once the second rotation is done; no fit or
//   table full skips the second rotation and shows once the first is done.
//   One request is processed at a time: the next request is taken only
//   after the previous result has left the output register.
//   The result is held in an output register until taken; a stalled receiver
//   holds the block, which then takes the next request only once free.
//   After reset: first-fit policy, one free segment of 1048575 units.
module fit_policy_segment_allocator_top
  import fpsa_pkg::*;
#(
  parameter int MaxSegments = MaxSegmentsDefault,
  parameter int SizeBits    = SizeBitsDefault,
  parameter int OwnerBits   = OwnerBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SizeBits-1:0]  request_size,
  input  logic [OwnerBits-1:0] owner_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [5:0]           segment_index,
  output logic                 was_split,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [19:0]          cfg_data
);

  localparam int IdxBits = $clog2(MaxSegments);
  localparam int CntBits = $clog2(MaxSegments + 1);
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(MaxSegments - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WRT  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state;
  logic [1:0]           policy;
  logic [IdxBits-1:0]   pos;
  logic [CntBits-1:0]   count;
  logic [SizeBits-1:0]  need;
  logic [OwnerBits-1:0] owner;
  logic                 found;
  logic [IdxBits-1:0]   pick;
  logic [SizeBits-1:0]  pick_size;
  logic [SizeBits-1:0]  best_val;

  chain_cmd_t           cmd;
  logic [SizeBits-1:0]  head_size;
  logic [OwnerBits-1:0] head_owner;
  logic                 head_used;
  logic [SizeBits-1:0]  init_size;

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = (state == S_IDLE) && !out_valid;

  logic cfg_fire, in_fire;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign in_fire  = in_valid && in_ready;
  assign init_size = SizeBits'(cfg_data);

  // candidate check on the head cell during the scan
  logic [SizeBits-1:0] surplus;
  logic cand, take, split_need, is_pick;
  assign surplus = head_size - need;
  assign cand = head_used && (head_owner == '0) && (head_size >= need);
  always_comb begin
    case (policy)
      POL_BEST:  take = cand && (!found || surplus < best_val);
      POL_WORST: take = cand && (!found || head_size > best_val);
      default:   take = cand && !found;
    endcase
  end
  assign split_need = pick_size > need;
  assign is_pick = (state == S_WRT) && (pos == pick);

  // chain command
  always_comb begin
    cmd.init   = (rst || (cfg_fire && cfg_index == REG_TOTAL));
    cmd.rotate = (state == S_SCAN) || (state == S_WRT);
    cmd.write  = is_pick;
    cmd.ins    = is_pick && split_need;
  end

  fpsa_chain #(.MaxSegments(MaxSegments), .SizeBits(SizeBits),
               .OwnerBits(OwnerBits)) u_chain (
    .clk(clk), .rst(rst), .cmd(cmd),
    .wr_size(rst ? SizeBits'(20'hFFFFF) : (is_pick ? need : init_size)),
    .wr_owner(owner), .ins_size(pick_size - need),
    .head_size(head_size), .head_owner(head_owner), .head_used(head_used)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      policy    <= POL_FIRST;
      count     <= CntBits'(1);
      out_valid <= 1'b0;
      pos       <= '0;
      found     <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_fire) begin
        if (cfg_index == REG_POLICY) policy <= cfg_data[1:0];
        else count <= CntBits'(1);
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            need  <= request_size;
            owner <= owner_id;
            found <= 1'b0;
            pos   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (take) begin
            found     <= 1'b1;
            pick      <= pos;
            pick_size <= head_size;
            best_val  <= (policy == POL_BEST) ? surplus : head_size;
          end
          if (pos == LastIdx) begin
            pos   <= '0;
            state <= S_DONE;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_DONE: begin
          if (!found) begin
            status <= ST_NOFIT; segment_index <= '0; was_split <= 1'b0;
            out_valid <= 1'b1; state <= S_IDLE;
          end else if (split_need && count >= CntBits'(MaxSegments)) begin
            status <= ST_FULL; segment_index <= '0; was_split <= 1'b0;
            out_valid <= 1'b1; state <= S_IDLE;
          end else begin
            state <= S_WRT;
          end
        end
        S_WRT: begin
          if (pos == LastIdx) begin
            status        <= ST_GRANT;
            segment_index <= 6'(pick);
            was_split     <= split_need;
            if (split_need) count <= count + 1'b1;
            out_valid     <= 1'b1;
            pos           <= '0;
            state         <= S_IDLE;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) &&
      $stable(segment_index) && $stable(was_split)))
    else $error("result dropped or changed while stalled");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= CntBits'(1)) && (count <= CntBits'(MaxSegments)))
    else $error("segment count out of range");
  a_grant_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRT && pos == LastIdx) |=> out_valid)
    else $error("grant not reported");

endmodule

[tb/tb_fit_policy_segment_allocator_top.sv]
// Testbench for fit_policy_segment_allocator_top: random and directed requests
// checked against a segment-table predictor kept in a scoreboard class.
// Depends on fpsa_pkg and the allocator RTL.
module tb_fit_policy_segment_allocator_top;
  import fpsa_pkg::*;

  localparam int NumSeg = 64;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [1:0] st;
    logic [5:0] idx;
    logic       split;
  } alloc_res_t;

  // Segment table predictor plus queue of expected results
  class alloc_scoreboard;
    logic [1:0]  policy;
    logic [19:0] total;
    logic [19:0] sizes[NumSeg];
    logic [15:0] owners[NumSeg];
    int          count;
    alloc_res_t  pending[$];
    int          errors;

    function new();
      policy = POL_FIRST;
      total  = 20'hFFFFF;
      errors = 0;
      reload();
    endfunction

    function void reload();
      for (int i = 0; i < NumSeg; i++) begin
        sizes[i]  = '0;
        owners[i] = '0;
      end
      sizes[0] = total;
      count    = 1;
    endfunction

    function void write_reg(logic idx, logic [19:0] data);
      if (idx == REG_POLICY) begin
        policy = data[1:0];
      end else begin
        total = data;
        reload();
      end
    endfunction

    // Pick a segment by policy and, on a grant, update the table
    function void note_request(logic [19:0] need, logic [15:0] owner);
      alloc_res_t r;
      logic       found;
      int         pick;
      logic [19:0] best;
      found = 1'b0;
      pick  = 0;
      best  = '0;
      r     = '0;
      for (int i = 0; i < count; i++) begin
        if (owners[i] == '0 && sizes[i] >= need) begin
          if (policy == POL_BEST) begin
            if (!found || sizes[i] - need < best) begin
              best = sizes[i] - need; pick = i; found = 1'b1;
            end
          end else if (policy == POL_WORST) begin
            if (!found || sizes[i] > best) begin
              best = sizes[i]; pick = i; found = 1'b1;
            end
          end else if (!found) begin
            pick = i; found = 1'b1;
          end
        end
      end
      if (!found) begin
        r.st = ST_NOFIT;
      end else if (sizes[pick] > need && count >= NumSeg) begin
        r.st = ST_FULL;
      end else begin
        if (sizes[pick] > need) begin
          for (int j = count; j > pick + 1; j--) begin
            sizes[j]  = sizes[j-1];
            owners[j] = owners[j-1];
          end
          sizes[pick+1]  = sizes[pick] - need;
          owners[pick+1] = '0;
          sizes[pick]    = need;
          count++;
          r.split = 1'b1;
        end
        owners[pick] = owner;
        r.st  = ST_GRANT;
        r.idx = pick[5:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(alloc_res_t got);
      alloc_res_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result st=%0d idx=%0d split=%0d", $time,
                 got.st, got.idx, got.split);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.st !== exp.st) begin
        $display("%0t: status exp %0d got %0d", $time, exp.st, got.st);
        errors++;
      end
      if (got.idx !== exp.idx) begin
        $display("%0t: segment_index exp %0d got %0d", $time, exp.idx, got.idx);
        errors++;
      end
      if (got.split !== exp.split) begin
        $display("%0t: was_split exp %0d got %0d", $time, exp.split, got.split);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [19:0] request_size = '0;
  logic [15:0] owner_id = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status;
  logic [5:0]  segment_index;
  logic        was_split;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = REG_POLICY;
  logic [19:0] cfg_data = '0;

  alloc_scoreboard sb = new();
  bit  calm = 0;   // no idling while set
  int  cycles = 0;

  always #2 clk = ~clk;

  fit_policy_segment_allocator_top i_dut (
    .clk, .rst, .in_valid, .in_ready, .request_size, .owner_id,
    .out_valid, .out_ready, .status, .segment_index, .was_split,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Result side: random stall, check each transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result(alloc_res_t'{status, segment_index, was_split});
      out_ready <= calm || ($urandom_range(0, 99) >= 16);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("fit_policy_segment_allocator_top test failed");
      $finish;
    end
  end

  task automatic send_req(logic [19:0] sz, logic [15:0] own);
    while (!calm && $urandom_range(0, 99) < 16) @(posedge clk);
    in_valid     <= 1;
    request_size <= sz;
    owner_id     <= own;
    do @(posedge clk); while (!in_ready);
    sb.note_request(sz, own);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * NumSeg + 8) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [19:0] data);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Random size: mostly small, sometimes anything
  function automatic logic [19:0] rand_size(int limit);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 20'($urandom_range(0, 20'hFFFFF));
    if (k == 1) return 20'd0;
    return 20'($urandom_range(1, limit));
  endfunction

  initial begin
    logic [1:0] pol;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: defaults, extremes, owner zero, zero size, overflow
    send_req(20'd0, 16'hFFFF);
    send_req(20'hFFFFF, 16'd0);
    send_req(20'd5, 16'h0001);
    send_req(20'hFFFFF, 16'h0002);
    send_req(20'hFFFFE, 16'h8000);
    write_cfg(REG_TOTAL, 20'd0);
    send_req(20'd0, 16'h1234);
    send_req(20'd1, 16'h1234);
    write_cfg(REG_TOTAL, 20'd1);
    send_req(20'd1, 16'h00FF);
    write_cfg(REG_POLICY, 20'd3);
    write_cfg(REG_TOTAL, 20'd100);
    send_req(20'd10, 16'h0003);
    send_req(20'd20, 16'h0000);
    send_req(20'd30, 16'h0004);
    send_req(20'd15, 16'h0005);
    write_cfg(REG_POLICY, {18'd0, POL_BEST});
    send_req(20'd5, 16'h0006);
    write_cfg(REG_POLICY, {18'd0, POL_WORST});
    send_req(20'd5, 16'h0007);

    // Random phases: rotate policy and total, one calm stretch
    for (int ph = 0; ph < 12; ph++) begin
      pol = 2'(ph % 4);
      write_cfg(REG_POLICY, {18'd0, pol});
      case (ph % 3)
        0: write_cfg(REG_TOTAL, 20'hFFFFF);
        1: write_cfg(REG_TOTAL, 20'($urandom_range(1, 2000)));
        default: write_cfg(REG_TOTAL, 20'($urandom_range(100, 20'hFFFFF)));
      endcase
      calm = (ph == 5);
      for (int n = 0; n < 95; n++) begin
        send_req(rand_size(ph % 3 == 1 ? 60 : 40000),
                 16'($urandom_range(0, 16'hFFFF)));
        if (n == 50 && ph == 2) drain();
      end
      calm = 0;
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("fit_policy_segment_allocator_top test passed");
    end else begin
      $display("fit_policy_segment_allocator_top test failed");
    end
    $finish;
  end
endmodule

[files.f]
rtl/fpsa_pkg.sv
rtl/fpsa_cell.sv
rtl/fpsa_chain.sv
rtl/fit_policy_segment_allocator_top.sv
tb/tb_fit_policy_segment_allocator_top.sv
